### hdl/pls_pkg.sv
// Shared types and codes for the positional list store.
// No dependencies; used by pls_store, pls_obuf and positional_list_store.
package pls_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_REMOVE_AT  = 2'd2,
    CMD_KEEP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // one result item as it leaves the block
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
    logic                     empty;
    status_e                  status;
  } item_t;

endpackage

### hdl/pls_store.sv
// Element memory: one write port, one read port, registered read data.
// Depends on pls_pkg for the value width.
module pls_store #(
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AddrW-1:0]                 waddr_i,
  input  logic signed [pls_pkg::ValueW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AddrW-1:0]                 raddr_i,
  output logic signed [pls_pkg::ValueW-1:0] rdata_o
);

  logic signed [pls_pkg::ValueW-1:0] mem [Depth];
  logic signed [pls_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pls_obuf.sv
// Two-entry output queue between the memory read path and the result stream.
// Depends on pls_pkg for the result item type.
module pls_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pls_pkg::item_t item_i,
  output logic [1:0]     count_o,
  output logic           valid_o,
  input  logic           ready_i,
  output pls_pkg::item_t item_o
);

  pls_pkg::item_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign item_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hdl/positional_list_store.sv
// Positional list store: ordered list in a circular buffer, full list streamed after each request.
// Results go via the read register and pls_obuf, one per cycle while m_tready stays high.
// Requests: none is taken in S_EMIT or S_WAIT, while the list is streamed and written back;
// the single memory read port streams the list, delete compaction rides the same pass.
// Reset: list empty at once; memory not cleared, and the empty marker's read is masked to zero.
// Depends on pls_pkg, pls_store and pls_obuf.
module positional_list_store #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // item_value
  output logic        m_tlast,   // is_last
  output logic [2:0]  m_tuser    // status[1:0], list_empty
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(LIST_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(LIST_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [SW-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  pls_pkg::status_e   status_q, status_d;
  logic               del_q, del_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      k_q, k_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_last_q, rd_last_d;
  logic               rd_empty_q, rd_empty_d;
  logic               rd_wr_q, rd_wr_d;
  logic [AW-1:0]      rd_waddr_q, rd_waddr_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  logic               accept;
  pls_pkg::cmd_e      cmd;
  logic               full;
  logic [AW-1:0]      new_head;
  logic               past_pos;
  logic [CW-1:0]      src;
  logic               is_last;
  logic               issue;
  logic [1:0]         ob_count;
  logic [2:0]         occupancy;
  logic               pop;
  pls_pkg::item_t     ob_in, ob_out;

  assign s_tready = (state_q == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cmd      = pls_pkg::cmd_e'(s_tuser);
  assign full     = (count_q == DEPTH_C);
  assign new_head = (head_q == '0) ? LAST_A : head_q - AW'(1);

  // emission pass: source skips the deleted slot, results written back one place down
  assign past_pos  = del_q && (k_q >= CW'(pos_q));
  assign src       = k_q + CW'(past_pos);
  assign is_last   = (count_q == '0) || (k_q == count_q - CW'(1));
  assign pop       = m_tvalid && m_tready;
  assign occupancy = {1'b0, ob_count} + {2'b00, rd_valid_q};
  assign issue     = (state_q == S_EMIT) && (occupancy <= {2'b00, pop} + 3'd1);
  assign mem_re    = issue;
  assign mem_raddr = wrap_add(head_q, src[AW-1:0]);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    status_d   = status_q;
    del_d      = del_q;
    pos_d      = pos_q;
    k_d        = k_q;
    rd_valid_d = 1'b0;
    rd_last_d  = rd_last_q;
    rd_empty_d = rd_empty_q;
    rd_wr_d    = 1'b0;
    rd_waddr_d = rd_waddr_q;
    mem_we     = 1'b0;
    mem_waddr  = rd_waddr_q;
    mem_wdata  = mem_rdata;

    if (rd_valid_q && rd_wr_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_EMIT;
          k_d      = '0;
          del_d    = 1'b0;
          status_d = pls_pkg::ST_DONE;
          case (cmd)
            pls_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = new_head;
                mem_wdata = s_tdata;
                head_d    = new_head;
                count_d   = count_q + CW'(1);
              end
            end
            pls_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                status_d = pls_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(head_q, count_q[AW-1:0]);
                mem_wdata = s_tdata;
                count_d   = count_q + CW'(1);
              end
            end
            pls_pkg::CMD_REMOVE_AT: begin
              if (s_tdata[31] || ({1'b0, s_tdata[30:0]} >= 32'(count_q))) begin
                status_d = pls_pkg::ST_IGNORED;
              end else begin
                del_d   = 1'b1;
                pos_d   = s_tdata[AW-1:0];
                count_d = count_q - CW'(1);
              end
            end
            default: begin
              status_d = pls_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (issue) begin
          rd_valid_d = 1'b1;
          rd_last_d  = is_last;
          rd_empty_d = (count_q == '0);
          rd_wr_d    = past_pos;
          rd_waddr_d = wrap_add(head_q, k_q[AW-1:0]);
          k_d        = k_q + CW'(1);
          if (is_last) begin
            state_d = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // last read lands and any write-back finishes here
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      status_q   <= pls_pkg::ST_DONE;
      del_q      <= 1'b0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
      rd_wr_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      status_q   <= status_d;
      del_q      <= del_d;
      k_q        <= k_d;
      rd_valid_q <= rd_valid_d;
      rd_wr_q    <= rd_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    rd_last_q  <= rd_last_d;
    rd_empty_q <= rd_empty_d;
    rd_waddr_q <= rd_waddr_d;
  end

  pls_store #(
    .Depth(LIST_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    ob_in.value  = rd_empty_q ? '0 : mem_rdata;
    ob_in.last   = rd_last_q;
    ob_in.empty  = rd_empty_q;
    ob_in.status = status_q;
  end

  pls_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rd_valid_q),
    .item_i (ob_in),
    .count_o(ob_count),
    .valid_o(m_tvalid),
    .ready_i(m_tready),
    .item_o (ob_out)
  );

  assign m_tdata = ob_out.value;
  assign m_tlast = ob_out.last;
  assign m_tuser = {ob_out.status, ob_out.empty};

endmodule

### hdl/pls_checker.sv
// Port-level checks for positional_list_store, bound to the top level.
// Depends on positional_list_store's port list only.
module pls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [2:0]  m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // empty marker is a single zero-valued last item
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
    else $error("empty marker malformed");

  // one request at a time: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);
